FILE: hw/rtl/lwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lwm_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int PAT_BYTES       = 16;
  localparam int LEN_W           = 5;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 64;

  localparam logic [7:0] WILD_RUN = 8'h25;
  localparam logic [7:0] WILD_ONE = 8'h5F;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pat;
    logic [LEN_W-1:0]          len;
  } lwm_cfg_t;

  typedef struct packed {
    logic       en;
    logic [7:0] pbyte;
  } lwm_cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lwm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lwm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  logic       no_character;

  modport source (output valid, output text_byte, output end_of_text,
                  output no_character, input ready);
  modport sink   (input valid, input text_byte, input end_of_text,
                  input no_character, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lwm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lwm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lwm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module lwm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lwm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lwm_pkg::DATA_W-1:0]   pwdata,
  output logic      [lwm_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output lwm_pkg::lwm_cfg_t                 cfg
);

  logic [63:0]               pat_low_r;
  logic [63:0]               pat_high_r;
  logic [lwm_pkg::LEN_W-1:0] len_r;
  logic [1:0]                idx;
  logic                      wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      len_r      <= '0;
    end else if (wr_en) begin
      unique case (idx)
        lwm_pkg::REG_PAT_LOW:  pat_low_r  <= pwdata[63:0];
        lwm_pkg::REG_PAT_HIGH: pat_high_r <= pwdata[63:0];
        lwm_pkg::REG_PAT_LEN:  len_r      <= pwdata[lwm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lwm_pkg::REG_PAT_LOW:  prdata = pat_low_r;
      lwm_pkg::REG_PAT_HIGH: prdata = pat_high_r;
      lwm_pkg::REG_PAT_LEN:  prdata = {{(lwm_pkg::DATA_W-lwm_pkg::LEN_W){1'b0}}, len_r};
      default:               prdata = '0;
    endcase
  end

  assign cfg.pat = {pat_high_r, pat_low_r};
  assign cfg.len = len_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lwm_close_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One position of the '%' closure: an active '%' also reaches the next position.
module lwm_close_cell (
  input  wire logic                  act,
  input  wire logic                  ci,
  input  wire lwm_pkg::lwm_cell_ctl_t ctl,
  output logic                       closed,
  output logic                       co
);

  assign closed = act | ci;
  assign co     = ctl.en & closed & (ctl.pbyte == lwm_pkg::WILD_RUN);

endmodule

`default_nettype wire

FILE: hw/rtl/lwm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lwm_cell (
  input  wire logic                   act,
  input  wire logic                   ci,
  input  wire logic                   shift_in,
  input  wire logic [7:0]             text_byte,
  input  wire lwm_pkg::lwm_cell_ctl_t ctl,
  output logic                        co,
  output logic                        shift_out,
  output logic                        nxt
);

  logic closed;
  logic pct;

  lwm_close_cell u_close (
    .act    (act),
    .ci     (ci),
    .ctl    (ctl),
    .closed (closed),
    .co     (co)
  );

  assign pct = ctl.pbyte == lwm_pkg::WILD_RUN;

  // '%' holds its own position; any other hit moves on to the next one
  assign shift_out = ctl.en & closed & ~pct &
                     ((ctl.pbyte == lwm_pkg::WILD_ONE) | (ctl.pbyte == text_byte));
  assign nxt       = co | shift_in;

endmodule

`default_nettype wire

FILE: hw/rtl/like_wildcard_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Result path: verdict register, then output register; a verdict waits while the
// output is held. Throughput: one item per cycle unless a verdict waits; the active
// set sits in a row of cells, one per pattern position, and the final '%' closure
// runs in a second stage. Reset (rst_n, synchronous): active set holds only
// position zero, pattern registers clear, no result pending.
module like_wildcard_matcher #(
  parameter int PATTERN_MAX = lwm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lwm_in_if.sink                           in_chan,
  lwm_out_if.source                        out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lwm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lwm_pkg::DATA_W-1:0]  pwdata,
  output logic      [lwm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int NW = $clog2(PATTERN_MAX + 1);

  lwm_pkg::lwm_cfg_t cfg;

  lwm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // saturate the length at the number of cells
  logic [NW-1:0] n_sat;
  assign n_sat = (cfg.len > lwm_pkg::LEN_W'(PATTERN_MAX)) ? NW'(PATTERN_MAX)
                                                          : cfg.len[NW-1:0];

  lwm_pkg::lwm_cell_ctl_t ctl [PATTERN_MAX];

  logic [PATTERN_MAX:0] act_r, act_nxt;
  logic [PATTERN_MAX:0] fin_r, fin_nxt;
  logic                 fin_v_r, fin_v_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_matched_r, out_matched_nxt;

  logic [PATTERN_MAX:0] ci, shift, adv;
  logic [PATTERN_MAX:0] cf, closed_f;
  logic [PATTERN_MAX:0] set_after;

  logic in_fire, fin_move;

  assign ci[0]    = 1'b0;
  assign shift[0] = 1'b0;
  assign cf[0]    = 1'b0;

  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
    assign ctl[p].en    = NW'(p) < n_sat;
    assign ctl[p].pbyte = cfg.pat[p];

    lwm_cell u_cell (
      .act       (act_r[p]),
      .ci        (ci[p]),
      .shift_in  (shift[p]),
      .text_byte (in_chan.text_byte),
      .ctl       (ctl[p]),
      .co        (ci[p+1]),
      .shift_out (shift[p+1]),
      .nxt       (adv[p])
    );

    lwm_close_cell u_fin_close (
      .act    (fin_r[p]),
      .ci     (cf[p]),
      .ctl    (ctl[p]),
      .closed (closed_f[p]),
      .co     (cf[p+1])
    );
  end

  assign adv[PATTERN_MAX]      = shift[PATTERN_MAX];
  assign closed_f[PATTERN_MAX] = fin_r[PATTERN_MAX] | cf[PATTERN_MAX];

  assign fin_move      = fin_v_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !fin_v_r || fin_move;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign set_after = in_chan.no_character ? act_r : adv;

  always_comb begin
    act_nxt         = act_r;
    fin_nxt         = fin_r;
    fin_v_nxt       = fin_v_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;

    if (fin_move) begin
      fin_v_nxt       = 1'b0;
      out_valid_nxt   = 1'b1;
      out_matched_nxt = closed_f[n_sat];
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      if (in_chan.end_of_text) begin
        // hand the final set to the verdict stage, restart the text
        fin_nxt   = set_after;
        fin_v_nxt = 1'b1;
        act_nxt   = {{PATTERN_MAX{1'b0}}, 1'b1};
      end else begin
        act_nxt = set_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= {{PATTERN_MAX{1'b0}}, 1'b1};
      fin_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      fin_v_r     <= fin_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r         <= fin_nxt;
    out_matched_r <= out_matched_nxt;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.matched = out_matched_r;

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.end_of_text |=> act_r == {{PATTERN_MAX{1'b0}}, 1'b1})
    else $error("active set not restarted after end of text");

  a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.no_character && !in_chan.end_of_text |=> act_r == $past(act_r))
    else $error("item without byte changed the active set");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.end_of_text |=> fin_v_r)
    else $error("end of text did not load the verdict stage");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_v_r))
    else $error("result raised without a pending verdict");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_like_wildcard_matcher.sv
`timescale 1ns / 1ps

module tb_like_wildcard_matcher;

  // Tracks the reachable pattern positions and queues one verdict per text.
  class verdict_board;
    logic [7:0]  pat_mem [lwm_pkg::PAT_BYTES];
    logic [4:0]  len_reg;
    logic [16:0] reach;
    bit          verdict_q [$];
    int          errors;

    function new();
      foreach (pat_mem[i]) pat_mem[i] = 8'h00;
      len_reg = '0;
      reach   = 17'd1;
      errors  = 0;
    endfunction

    function int used_len();
      return (len_reg > lwm_pkg::PATTERN_MAX_DEF) ? lwm_pkg::PATTERN_MAX_DEF : int'(len_reg);
    endfunction

    // let every reachable '%' also reach the position after it
    function logic [16:0] close_reach(logic [16:0] s);
      int n;
      n = used_len();
      for (int p = 0; p < n; p++)
        if (s[p] && pat_mem[p] == lwm_pkg::WILD_RUN) s[p+1] = 1'b1;
      return s;
    endfunction

    function logic [16:0] step_reach(logic [16:0] s, logic [7:0] c);
      logic [16:0] nxt;
      int          n;
      nxt = '0;
      n   = used_len();
      for (int p = 0; p < n; p++) begin
        if (s[p]) begin
          if (pat_mem[p] == lwm_pkg::WILD_RUN) nxt[p] = 1'b1;
          else if (pat_mem[p] == lwm_pkg::WILD_ONE || pat_mem[p] == c) nxt[p+1] = 1'b1;
        end
      end
      return nxt;
    endfunction

    function void note_config(logic [1:0] idx, logic [63:0] v);
      case (idx)
        lwm_pkg::REG_PAT_LOW: begin
          for (int i = 0; i < 8; i++) pat_mem[i] = v[8*i +: 8];
        end
        lwm_pkg::REG_PAT_HIGH: begin
          for (int i = 0; i < 8; i++) pat_mem[8+i] = v[8*i +: 8];
        end
        lwm_pkg::REG_PAT_LEN: len_reg = v[4:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic eot, logic noch);
      logic [16:0] s;
      if (!noch) reach = step_reach(close_reach(reach), b);
      if (eot) begin
        s = close_reach(reach);
        verdict_q.push_back(s[used_len()]);
        reach = 17'd1;
      end
    endfunction

    function void check_result(logic m);
      bit e;
      if (verdict_q.size() == 0) begin
        $error("matched: no verdict pending, actual %0b", m);
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (m !== e) begin
          $error("matched: expected %0b, actual %0b", e, m);
          errors++;
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lwm_pkg::ADDR_W-1:0] paddr;
  logic [lwm_pkg::DATA_W-1:0] pwdata;
  logic [lwm_pkg::DATA_W-1:0] prdata;
  logic pready;

  lwm_in_if  in_chan ();
  lwm_out_if out_chan ();

  like_wildcard_matcher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  verdict_board verdicts = new();

  bit         calm;
  int         sent_items;
  logic [7:0] cur_pat [lwm_pkg::PAT_BYTES];
  int         cur_len;
  logic [7:0] text_q [$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= calm || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) verdicts.check_result(out_chan.matched);
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic send_item(input logic [7:0] b, input logic eot, input logic noch);
    calm = (sent_items >= 300 && sent_items < 420);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.text_byte    <= b;
    in_chan.end_of_text  <= eot;
    in_chan.no_character <= noch;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    verdicts.note_input(b, eot, noch);
    if (!noch || eot) sent_items++;
  endtask

  // Send text_q as one text; the end can ride on the last byte or come alone.
  task automatic send_text(input bit eot_alone);
    int last;
    last = text_q.size() - 1;
    if (text_q.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      for (int i = 0; i <= last; i++) begin
        if ($urandom_range(0, 99) < 8) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_item(text_q[i], (i == last) && !eot_alone, 1'b0);
      end
      if (eot_alone) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
  endtask

  // Hold the sender until every verdict is in, then let the pipe settle.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (verdicts.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] n);
    logic [63:0] vals [3];
    logic [1:0]  idx [3];
    vals[0] = lo;
    vals[1] = hi;
    vals[2] = {59'd0, n};
    idx[0]  = lwm_pkg::REG_PAT_LOW;
    idx[1]  = lwm_pkg::REG_PAT_HIGH;
    idx[2]  = lwm_pkg::REG_PAT_LEN;
    for (int k = 0; k < 3; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[k], 3'b000};
      pwdata  <= vals[k];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      verdicts.note_config(idx[k], vals[k]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      cur_pat[i]   = lo[8*i +: 8];
      cur_pat[8+i] = hi[8*i +: 8];
    end
    cur_len = (n > lwm_pkg::PATTERN_MAX_DEF) ? lwm_pkg::PATTERN_MAX_DEF : int'(n);
  endtask

  function automatic logic [7:0] rand_pat_byte();
    case ($urandom_range(0, 9))
      0, 1:    return "a";
      2, 3:    return "b";
      4, 5:    return lwm_pkg::WILD_RUN;
      6, 7:    return lwm_pkg::WILD_ONE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3, 4, 5: return "b";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a text in text_q: mostly one the pattern accepts, some broken, some noise.
  task automatic make_text();
    int kind;
    int pos;
    kind = $urandom_range(0, 9);
    text_q.delete();
    if (kind == 9) begin
      repeat ($urandom_range(0, 8)) text_q.push_back(rand_text_byte());
    end else begin
      for (int p = 0; p < cur_len; p++) begin
        if (cur_pat[p] == lwm_pkg::WILD_RUN)
          repeat ($urandom_range(0, 3)) text_q.push_back(rand_text_byte());
        else if (cur_pat[p] == lwm_pkg::WILD_ONE)
          text_q.push_back(rand_text_byte());
        else
          text_q.push_back(cur_pat[p]);
      end
      if (kind >= 7) begin
        pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: if (text_q.size() != 0) text_q.delete(pos);
          1: if (text_q.size() != 0) text_q[pos] = 8'($urandom_range(0, 255));
          default: text_q.push_back(rand_text_byte());
        endcase
      end
    end
  endtask

  initial begin
    logic [7:0]  pbytes [lwm_pkg::PAT_BYTES];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  n;
    int          sel;

    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_chan.valid        = 1'b0;
    in_chan.text_byte    = 8'h00;
    in_chan.end_of_text  = 1'b0;
    in_chan.no_character = 1'b0;
    out_chan.ready       = 1'b0;
    calm                 = 1'b0;
    sent_items           = 0;
    cur_len              = 0;
    foreach (cur_pat[i]) cur_pat[i] = 8'h00;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern out of reset: only the empty text matches
    text_q.delete();
    send_text(1'b0);
    text_q = {8'h78};
    send_text(1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    text_q.delete();
    send_text(1'b0);
    drain();

    // length above the limit, extreme literal bytes, runs of '%'
    load_pattern({lwm_pkg::WILD_RUN, lwm_pkg::WILD_RUN, lwm_pkg::WILD_RUN, lwm_pkg::WILD_RUN,
                  lwm_pkg::WILD_ONE, 8'hFF, lwm_pkg::WILD_RUN, 8'h00},
                 {8{lwm_pkg::WILD_RUN}}, 5'd31);
    text_q = {8'h00, 8'hFF, 8'h07};
    send_text(1'b0);
    send_text(1'b1);
    text_q = {8'h00};
    send_text(1'b0);
    text_q = {8'h01, 8'h00, 8'hFF, 8'h05};
    send_text(1'b0);
    text_q = {8'h00, 8'h11, 8'h22, 8'hFF, 8'h80, 8'hFF};
    send_text(1'b0);
    drain();

    // full-length literal pattern
    load_pattern(64'h0, {64{1'b1}}, 5'd16);
    text_q.delete();
    repeat (8) text_q.push_back(8'h00);
    repeat (8) text_q.push_back(8'hFF);
    send_text(1'b0);
    // drop the last byte so the text falls one short
    text_q.delete(text_q.size() - 1);
    send_text(1'b1);
    drain();

    load_pattern({64{1'b1}}, 64'h0, 5'd0);
    text_q.delete();
    send_text(1'b0);
    text_q = {8'hFF};
    send_text(1'b0);
    drain();

    // bytes past the length are never looked at
    load_pattern(64'hFFFF_FFFF_FFFF_2525, {8{lwm_pkg::WILD_ONE}}, 5'd2);
    text_q.delete();
    send_text(1'b0);
    text_q = {8'h41, 8'h42};
    send_text(1'b0);
    drain();

    while (sent_items < 650) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) n = 5'($urandom_range(0, 6));
      else if (sel < 9) n = 5'($urandom_range(7, 16));
      else n = 5'($urandom_range(17, 31));
      for (int i = 0; i < lwm_pkg::PAT_BYTES; i++)
        pbytes[i] = (i < n) ? rand_pat_byte() : 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++) begin
        lo[8*i +: 8] = pbytes[i];
        hi[8*i +: 8] = pbytes[8+i];
      end
      load_pattern(lo, hi, n);
      repeat ($urandom_range(5, 15)) begin
        make_text();
        send_text($urandom_range(0, 3) == 0);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (verdicts.errors == 0 && verdicts.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
